@@ hw/rtl/pur_pkg.sv @@
// ----------------------------------------------------------------------------
// pur_pkg
// Shared types and constants of the polled uart receiver: configuration
// register indexes, receive phases, event codes and the per-channel state.
// ----------------------------------------------------------------------------
package pur_pkg;

    // channel count default and field widths
    localparam int DEFAULT_CHANNELS = 4;
    localparam int CHAN_W           = 2;
    localparam int BT_COUNT         = 4;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS_CH0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS_CH1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS_CH2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS_CH3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_START    = 3'd4;

    localparam logic [7:0] BIT_TICKS_RESET = 8'd104;

    // commands
    localparam logic CMD_POLL = 1'b0;
    localparam logic CMD_TAKE = 1'b1;

    // receive phases
    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_START = 4'd1;
    localparam logic [3:0] PH_FIRST = 4'd2;
    localparam logic [3:0] PH_STOP  = 4'd10;

    // event codes
    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_START_EDGE = 3'd1;
    localparam logic [2:0] EV_GLITCH     = 3'd2;
    localparam logic [2:0] EV_DATA_BIT   = 3'd3;
    localparam logic [2:0] EV_BYTE_DONE  = 3'd4;
    localparam logic [2:0] EV_FRAMING    = 3'd5;

    // per-channel receiver state
    typedef struct packed {
        logic [3:0] phase;
        logic [7:0] shift_byte;
        logic [7:0] last_time;
        logic [7:0] held_byte;
        logic       waiting;
    } chan_state_t;

    // result of one item
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       byte_waiting;
        logic [2:0] event_res;
    } result_t;

endpackage

@@ hw/rtl/pur_cfg.sv @@
// ----------------------------------------------------------------------------
// pur_cfg
// Configuration registers: bit period of each channel and the start
// recheck bypass.
// ----------------------------------------------------------------------------
module pur_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [pur_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pur_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [7:0]                       bit_ticks [pur_pkg::BT_COUNT],
    output logic                             skip_start
);

    logic [7:0] bit_ticks_reg [pur_pkg::BT_COUNT];
    logic       skip_start_reg;

    // register writes, indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pur_pkg::BT_COUNT; i++)
            begin
                bit_ticks_reg[i] <= pur_pkg::BIT_TICKS_RESET;
            end
            skip_start_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pur_pkg::CFG_BIT_TICKS_CH0: bit_ticks_reg[0] <= cfg_data[7:0];
                pur_pkg::CFG_BIT_TICKS_CH1: bit_ticks_reg[1] <= cfg_data[7:0];
                pur_pkg::CFG_BIT_TICKS_CH2: bit_ticks_reg[2] <= cfg_data[7:0];
                pur_pkg::CFG_BIT_TICKS_CH3: bit_ticks_reg[3] <= cfg_data[7:0];
                pur_pkg::CFG_SKIP_START:    skip_start_reg   <= cfg_data[0];
                default:                    skip_start_reg   <= skip_start_reg;
            endcase
        end
    end

    assign bit_ticks  = bit_ticks_reg;
    assign skip_start = skip_start_reg;

endmodule

@@ hw/rtl/pur_step.sv @@
// ----------------------------------------------------------------------------
// pur_step
// Next-state logic of one channel for one item: start detection, start
// recheck, data bit sampling, stop check and the take command.
// ----------------------------------------------------------------------------
module pur_step (
    input  logic                  command,
    input  logic                  line_level,
    input  logic [7:0]            time_now,
    input  logic [7:0]            bit_ticks,
    input  logic                  skip_start,
    input  pur_pkg::chan_state_t  cur,
    output pur_pkg::chan_state_t  nxt,
    output pur_pkg::result_t      res
);

    logic [7:0] gap;
    logic [7:0] start_delta;
    logic       bit_due;
    logic       start_due;
    logic [2:0] ev;

    // timing checks against the last sample point
    assign gap         = time_now - cur.last_time;
    assign start_delta = bit_ticks >> 3;
    assign bit_due     = (gap >= bit_ticks);
    assign start_due   = skip_start || (gap >= start_delta);

    // receive state machine
    always_comb
    begin
        nxt = cur;
        ev  = pur_pkg::EV_NONE;
        if (command == pur_pkg::CMD_TAKE)
        begin
            nxt.waiting = 1'b0;
        end
        else
        begin
            case (cur.phase)
                pur_pkg::PH_IDLE:
                begin
                    if (!line_level)
                    begin
                        nxt.last_time  = time_now;
                        nxt.shift_byte = 8'h00;
                        nxt.phase      = skip_start ? pur_pkg::PH_FIRST : pur_pkg::PH_START;
                        ev             = pur_pkg::EV_START_EDGE;
                    end
                end
                pur_pkg::PH_START:
                begin
                    if (start_due)
                    begin
                        if (!skip_start)
                        begin
                            nxt.last_time = cur.last_time + start_delta;
                        end
                        if (!line_level)
                        begin
                            nxt.phase = pur_pkg::PH_FIRST;
                        end
                        else
                        begin
                            nxt.phase = pur_pkg::PH_IDLE;
                            ev        = pur_pkg::EV_GLITCH;
                        end
                    end
                end
                pur_pkg::PH_STOP:
                begin
                    if (bit_due)
                    begin
                        nxt.last_time = cur.last_time + bit_ticks;
                        if (line_level)
                        begin
                            nxt.held_byte = cur.shift_byte;
                            nxt.waiting   = 1'b1;
                            ev            = pur_pkg::EV_BYTE_DONE;
                        end
                        else
                        begin
                            ev = pur_pkg::EV_FRAMING;
                        end
                        nxt.phase = pur_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    if (cur.phase > pur_pkg::PH_STOP)
                    begin
                        nxt.phase = pur_pkg::PH_IDLE;
                    end
                    else if (bit_due)
                    begin
                        nxt.last_time  = cur.last_time + bit_ticks;
                        nxt.shift_byte = {line_level, cur.shift_byte[7:1]};
                        nxt.phase      = cur.phase + 4'd1;
                        ev             = pur_pkg::EV_DATA_BIT;
                    end
                end
            endcase
        end
    end

    // result fields: flag before clearing on take, after update on poll
    always_comb
    begin
        res.rx_byte      = nxt.held_byte;
        res.byte_waiting = (command == pur_pkg::CMD_TAKE) ? cur.waiting : nxt.waiting;
        res.event_res    = ev;
    end

endmodule

@@ hw/rtl/polled_uart_receiver.sv @@
// ----------------------------------------------------------------------------
// polled_uart_receiver
// Multi-channel polled 8N1 uart receiver: each item polls one channel's line
// or takes its received byte; one result item per input item.
// Path: input register, then channel update into the result register.
// Throughput: one item per cycle while out_stall does not hold the result,
// also back to back on the same channel.
// Reset: asynchronous, active low; clears all channel state, sets every bit
// period to 104 and the start recheck bypass to 0.
// ----------------------------------------------------------------------------
module polled_uart_receiver #(
    parameter int CHANNELS = pur_pkg::DEFAULT_CHANNELS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_write,
    input  logic [pur_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pur_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             command,
    input  logic [pur_pkg::CHAN_W-1:0]       channel,
    input  logic                             line_level,
    input  logic [7:0]                       time_now,
    // output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       rx_byte,
    output logic                             byte_waiting,
    output logic [2:0]                       event_res
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [7:0] bit_ticks [pur_pkg::BT_COUNT];
    logic       skip_start;

    // input register
    logic                        s1_valid_reg;
    logic                        s1_command_reg;
    logic [pur_pkg::CHAN_W-1:0]  s1_channel_reg;
    logic                        s1_level_reg;
    logic [7:0]                  s1_time_reg;

    // result register
    logic                        out_valid_reg;
    pur_pkg::result_t            res_reg;

    // channel state
    pur_pkg::chan_state_t        st_reg [CHANNELS];

    logic                        out_load;
    logic                        advance;
    logic                        in_accept;
    logic                        in_range;
    logic [CH_W-1:0]             ch_idx;
    pur_pkg::chan_state_t        cur_st;
    pur_pkg::chan_state_t        st_next;
    pur_pkg::result_t            step_res;
    pur_pkg::result_t            res_next;

    pur_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .bit_ticks  (bit_ticks),
        .skip_start (skip_start)
    );

    // handshake: result register frees when empty or taken
    assign out_load  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_load;
    assign in_stall  = s1_valid_reg && !out_load;
    assign in_accept = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_command_reg <= command;
            s1_channel_reg <= channel;
            s1_level_reg   <= line_level;
            s1_time_reg    <= time_now;
        end
    end

    // addressed channel
    assign in_range = (32'(s1_channel_reg) < CHANNELS);
    assign ch_idx   = CH_W'(s1_channel_reg);
    assign cur_st   = st_reg[ch_idx];

    pur_step u_step (
        .command    (s1_command_reg),
        .line_level (s1_level_reg),
        .time_now   (s1_time_reg),
        .bit_ticks  (bit_ticks[s1_channel_reg]),
        .skip_start (skip_start),
        .cur        (cur_st),
        .nxt        (st_next),
        .res        (step_res)
    );

    // channels beyond the count report all zero
    assign res_next = in_range ? step_res : '0;

    // channel state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                st_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (advance && in_range && (ch_idx == CH_W'(i)))
                begin
                    st_reg[i] <= st_next;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rx_byte      = res_reg.rx_byte;
    assign byte_waiting = res_reg.byte_waiting;
    assign event_res    = res_reg.event_res;

endmodule

@@ tb/uart_rx_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_rx_checker
// Watches the configuration port and both item channels of the polled uart
// receiver. It keeps its own copy of the per-channel receive state, predicts
// the result of every accepted input item and compares each accepted result
// with the oldest prediction.
// ----------------------------------------------------------------------------
module uart_rx_checker
    import pur_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  command,
    input  logic [CHAN_W-1:0]     channel,
    input  logic                  line_level,
    input  logic [7:0]            time_now,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [7:0]            rx_byte,
    input  logic                  byte_waiting,
    input  logic [2:0]            event_res,
    output int                    fail_count,
    output int                    open_count,
    output int                    result_count,
    output int                    bytes_seen,
    output int                    framing_seen,
    output int                    glitch_seen
);

    // configuration copy
    logic [7:0] period_ticks [BT_COUNT];
    logic       skip_recheck;

    // per-channel receive state
    logic [3:0] ch_phase [BT_COUNT];
    logic [7:0] ch_shift [BT_COUNT];
    logic [7:0] ch_last  [BT_COUNT];
    logic [7:0] ch_held  [BT_COUNT];
    logic       ch_flag  [BT_COUNT];

    result_t awaited_results[$];
    result_t oldest;

    // sample slot check: advances the channel's reference time when due
    function automatic bit slot_due(int ch, logic [7:0] now, logic [7:0] span);
        logic [7:0] gap;
        gap = now - ch_last[ch];
        if (gap >= span)
        begin
            ch_last[ch] = ch_last[ch] + span;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // one poll or take on one channel
    function automatic result_t receive_step(logic cmd, int ch, logic lvl, logic [7:0] now);
        result_t    r;
        logic [2:0] ev;
        bit         check_now;
        ev = EV_NONE;
        if (cmd == CMD_TAKE)
        begin
            r.rx_byte      = ch_held[ch];
            r.byte_waiting = ch_flag[ch];
            r.event_res    = EV_NONE;
            ch_flag[ch]    = 1'b0;
            return r;
        end
        case (ch_phase[ch])
            PH_IDLE:
            begin
                if (!lvl)
                begin
                    ch_last[ch]  = now;
                    ch_shift[ch] = 8'h00;
                    ch_phase[ch] = skip_recheck ? PH_FIRST : PH_START;
                    ev           = EV_START_EDGE;
                end
            end
            PH_START:
            begin
                // with the recheck bypassed no timing is applied
                if (skip_recheck)
                    check_now = 1'b1;
                else
                    check_now = slot_due(ch, now, period_ticks[ch] >> 3);
                if (check_now)
                begin
                    if (!lvl)
                        ch_phase[ch] = PH_FIRST;
                    else
                    begin
                        ch_phase[ch] = PH_IDLE;
                        ev           = EV_GLITCH;
                    end
                end
            end
            PH_STOP:
            begin
                if (slot_due(ch, now, period_ticks[ch]))
                begin
                    if (lvl)
                    begin
                        ch_held[ch] = ch_shift[ch];
                        ch_flag[ch] = 1'b1;
                        ev          = EV_BYTE_DONE;
                    end
                    else
                        ev = EV_FRAMING;
                    ch_phase[ch] = PH_IDLE;
                end
            end
            default:
            begin
                if (ch_phase[ch] > PH_STOP)
                    ch_phase[ch] = PH_IDLE;
                else if (slot_due(ch, now, period_ticks[ch]))
                begin
                    ch_shift[ch] = {lvl, ch_shift[ch][7:1]};
                    ch_phase[ch] = ch_phase[ch] + 4'd1;
                    ev           = EV_DATA_BIT;
                end
            end
        endcase
        r.rx_byte      = ch_held[ch];
        r.byte_waiting = ch_flag[ch];
        r.event_res    = ev;
        return r;
    endfunction

    // track config writes, predict accepted items, compare accepted results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < BT_COUNT; c++)
            begin
                period_ticks[c] = BIT_TICKS_RESET;
                ch_phase[c]     = PH_IDLE;
                ch_shift[c]     = 8'h00;
                ch_last[c]      = 8'h00;
                ch_held[c]      = 8'h00;
                ch_flag[c]      = 1'b0;
            end
            skip_recheck = 1'b0;
            awaited_results.delete();
            fail_count   = 0;
            result_count = 0;
            bytes_seen   = 0;
            framing_seen = 0;
            glitch_seen  = 0;
            open_count   <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_BIT_TICKS_CH0: period_ticks[0] = cfg_data;
                    CFG_BIT_TICKS_CH1: period_ticks[1] = cfg_data;
                    CFG_BIT_TICKS_CH2: period_ticks[2] = cfg_data;
                    CFG_BIT_TICKS_CH3: period_ticks[3] = cfg_data;
                    CFG_SKIP_START:    skip_recheck    = cfg_data[0];
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] unexpected result: byte %02h waiting %0d event %0d",
                                 $realtime, rx_byte, byte_waiting, event_res);
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    result_count++;
                    if (oldest.event_res == EV_BYTE_DONE)
                        bytes_seen++;
                    if (oldest.event_res == EV_FRAMING)
                        framing_seen++;
                    if (oldest.event_res == EV_GLITCH)
                        glitch_seen++;
                    if (rx_byte !== oldest.rx_byte || byte_waiting !== oldest.byte_waiting ||
                        event_res !== oldest.event_res)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("[%0t] result %0d mismatch: expected byte %02h waiting %0d event %0d, got byte %02h waiting %0d event %0d",
                                     $realtime, result_count, oldest.rx_byte,
                                     oldest.byte_waiting, oldest.event_res,
                                     rx_byte, byte_waiting, event_res);
                    end
                end
            end

            if (in_valid && !in_stall)
                awaited_results.push_back(receive_step(command, int'(channel),
                                                       line_level, time_now));

            open_count <= awaited_results.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the polled uart receiver. A directed opening walks
// takes, a start glitch and one complete frame; then several bit-period and
// start-recheck settings are run with interleaved uart frames on all four
// channels, some broken or noisy, mixed with takes, under random idling and result
// stalls, but for the last setting. uart_rx_checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import pur_pkg::*;

    localparam int SETTINGS_RUN = 7;
    localparam int ITEMS_EACH   = 250;
    localparam int QUIET_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 8;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_BIT_TICKS_CH0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic                  command      = CMD_POLL;
    logic [CHAN_W-1:0]     channel      = '0;
    logic                  line_level   = 1'b1;
    logic [7:0]            time_now     = 8'h00;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [7:0]            rx_byte;
    logic                  byte_waiting;
    logic [2:0]            event_res;

    int fail_count, open_count, result_count, bytes_seen, framing_seen, glitch_seen;

    // stimulus side copy of the configuration and the line generators
    logic [7:0] period_cfg [BT_COUNT] = '{default: BIT_TICKS_RESET};
    int         ch_time    [BT_COUNT] = '{default: 0};
    int         frame_t0   [BT_COUNT];
    bit         frame_on   [BT_COUNT] = '{default: 1'b0};
    bit         frame_bad  [BT_COUNT];
    logic [7:0] frame_data [BT_COUNT];

    bit idle_on  = 1'b1;
    bit stall_on = 1'b1;
    int sent_count  = 0;
    int quiet_count = 0;

    polled_uart_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .channel      (channel),
        .line_level   (line_level),
        .time_now     (time_now),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .rx_byte      (rx_byte),
        .byte_waiting (byte_waiting),
        .event_res    (event_res)
    );

    uart_rx_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .channel      (channel),
        .line_level   (line_level),
        .time_now     (time_now),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .rx_byte      (rx_byte),
        .byte_waiting (byte_waiting),
        .event_res    (event_res),
        .fail_count   (fail_count),
        .open_count   (open_count),
        .result_count (result_count),
        .bytes_seen   (bytes_seen),
        .framing_seen (framing_seen),
        .glitch_seen  (glitch_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result stall bursts
    initial
    begin
        forever
        begin
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (stall_on)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_count <= 0;
        else
        begin
            quiet_count <= quiet_count + 1;
            if (quiet_count >= QUIET_LIMIT)
            begin
                $display("watchdog: no item accepted for %0d cycles", QUIET_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // offer one item, with an optional idle burst first, and wait for acceptance
    task automatic send_item(input logic cmd, input logic [CHAN_W-1:0] ch,
                             input logic lvl, input logic [7:0] t);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        channel    <= ch;
        line_level <= lvl;
        time_now   <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // stop offering items and wait until every result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (open_count != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3, input logic skip);
        write_reg(CFG_BIT_TICKS_CH0, b0);
        write_reg(CFG_BIT_TICKS_CH1, b1);
        write_reg(CFG_BIT_TICKS_CH2, b2);
        write_reg(CFG_BIT_TICKS_CH3, b3);
        write_reg(CFG_SKIP_START, {7'd0, skip});
        cfg_write     <= 1'b0;
        period_cfg[0] = b0;
        period_cfg[1] = b1;
        period_cfg[2] = b2;
        period_cfg[3] = b3;
    endtask

    // one random item: mostly polls that follow a uart frame, some takes and noise
    task automatic random_item();
        int   c;
        int   bit_idx;
        logic lvl;
        c = $urandom_range(0, 3);
        if ($urandom_range(0, 99) < 15)
        begin
            send_item(CMD_TAKE, CHAN_W'(c), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
            return;
        end
        ch_time[c] += $urandom_range(1, period_cfg[c] / 3 + 1);
        lvl = 1'b1;
        if (frame_on[c])
        begin
            bit_idx = (ch_time[c] - frame_t0[c]) / int'(period_cfg[c]);
            if (bit_idx == 0)
                lvl = 1'b0;
            else if (bit_idx <= 8)
                lvl = frame_data[c][bit_idx - 1];
            else if (bit_idx == 9)
                lvl = !frame_bad[c];
            else
                frame_on[c] = 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            // line drops: a new frame starts here
            frame_on[c]   = 1'b1;
            frame_t0[c]   = ch_time[c];
            frame_data[c] = 8'($urandom_range(0, 255));
            frame_bad[c]  = ($urandom_range(0, 9) == 0);
            lvl           = 1'b0;
        end
        // occasional line noise
        if ($urandom_range(0, 24) == 0)
            lvl = !lvl;
        send_item(CMD_POLL, CHAN_W'(c), lvl, ch_time[c][7:0]);
    endtask

    // main sequence
    initial
    begin
        logic [7:0] rnd_bt [BT_COUNT];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: takes on empty channels
        for (int c = 0; c < BT_COUNT; c++)
            send_item(CMD_TAKE, CHAN_W'(c), 1'b0, 8'h00);
        // idle line stays idle
        send_item(CMD_POLL, 2'd2, 1'b1, 8'hff);
        // start edge, early poll, then a high recheck across the time wrap: glitch
        send_item(CMD_POLL, 2'd0, 1'b0, 8'd250);
        send_item(CMD_POLL, 2'd0, 1'b0, 8'd255);
        send_item(CMD_POLL, 2'd0, 1'b1, 8'd7);
        // a full frame of a5 on channel three at the reset bit period
        send_item(CMD_POLL, 2'd3, 1'b0, 8'd0);
        send_item(CMD_POLL, 2'd3, 1'b0, 8'd13);
        for (int k = 0; k < 8; k++)
            send_item(CMD_POLL, 2'd3, 1'(8'ha5 >> k), 8'(13 + 104 * (k + 1)));
        send_item(CMD_POLL, 2'd3, 1'b1, 8'(13 + 104 * 9));
        send_item(CMD_TAKE, 2'd3, 1'b1, 8'h5a);
        send_item(CMD_TAKE, 2'd3, 1'b0, 8'h00);
        drain_results();

        // random part over several register settings
        for (int s = 0; s < SETTINGS_RUN; s++)
        begin
            case (s)
                0: ;
                1: set_config(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
                2: set_config(8'd1, 8'd2, 8'd7, 8'd8, 1'b1);
                3: set_config(8'd255, 8'd1, 8'd104, 8'd16, 1'b1);
                default:
                begin
                    for (int c = 0; c < BT_COUNT; c++)
                        rnd_bt[c] = $urandom_range(0, 1) ? 8'($urandom_range(1, 16))
                                                         : 8'($urandom_range(1, 255));
                    set_config(rnd_bt[0], rnd_bt[1], rnd_bt[2], rnd_bt[3],
                               1'($urandom_range(0, 1)));
                end
            endcase
            for (int c = 0; c < BT_COUNT; c++)
                frame_on[c] = 1'b0;
            // the last setting runs flat out
            idle_on  = (s != SETTINGS_RUN - 1);
            stall_on = (s != SETTINGS_RUN - 1);
            for (int i = 0; i < ITEMS_EACH; i++)
                random_item();
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Summary: %0d items over %0d register settings, %0d results checked",
                 sent_count, SETTINGS_RUN, result_count);
        $display("Summary: %0d bytes received, %0d framing errors, %0d start glitches",
                 bytes_seen, framing_seen, glitch_seen);
        if (fail_count == 0 && open_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/pur_pkg.sv
hw/rtl/pur_cfg.sv
hw/rtl/pur_step.sv
hw/rtl/polled_uart_receiver.sv
tb/uart_rx_checker.sv
tb/testbench.sv
